FILE: hdl/xed_pkg.sv
// Shared types, character codes and decode functions for the XML entity decoder.
package xed_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int MAX_OUT     = 6;
  localparam int SEG_MAX     = 5;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  typedef enum logic [4:0] {
    PH_IDLE, PH_AMP, PH_HASH, PH_DEC, PH_HEX,
    PH_L, PH_LT, PH_G, PH_GT,
    PH_A, PH_AM, PH_AMPW, PH_AP, PH_APO, PH_APOS,
    PH_Q, PH_QU, PH_QUO, PH_QUOT
  } phase_t;

  typedef enum logic [1:0] {
    ACT_NONE, ACT_NUM, ACT_DONE, ACT_HELD
  } act_t;

  typedef struct packed {
    logic [SEG_MAX-1:0][7:0] b;
    logic [2:0]              len;
  } seg_t;

  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] b;
    logic [2:0]              cnt;
  } group_t;

  typedef struct packed {
    logic   valid;
    group_t grp;
  } q_head_t;

  function automatic phase_t named_next(input phase_t ph, input logic [7:0] c);
    phase_t nx;
    nx = PH_IDLE;
    case (ph)
      PH_AMP: begin
        if (c == "l") nx = PH_L;
        else if (c == "g") nx = PH_G;
        else if (c == "a") nx = PH_A;
        else if (c == "q") nx = PH_Q;
        else if (c == CH_HASH) nx = PH_HASH;
      end
      PH_L:   if (c == "t") nx = PH_LT;
      PH_G:   if (c == "t") nx = PH_GT;
      PH_A: begin
        if (c == "m") nx = PH_AM;
        else if (c == "p") nx = PH_AP;
      end
      PH_AM:  if (c == "p") nx = PH_AMPW;
      PH_AP:  if (c == "o") nx = PH_APO;
      PH_APO: if (c == "s") nx = PH_APOS;
      PH_Q:   if (c == "u") nx = PH_QU;
      PH_QU:  if (c == "o") nx = PH_QUO;
      PH_QUO: if (c == "t") nx = PH_QUOT;
      default: nx = PH_IDLE;
    endcase
    return nx;
  endfunction

  function automatic logic [7:0] done_char(input phase_t ph);
    logic [7:0] c;
    case (ph)
      PH_LT:   c = "<";
      PH_GT:   c = ">";
      PH_AMPW: c = CH_AMP;
      PH_APOS: c = "'";
      PH_QUOT: c = 8'h22;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // The ampersand followed by the letters matched so far.
  function automatic seg_t held_seg(input phase_t ph);
    seg_t s;
    s      = '0;
    s.b[0] = CH_AMP;
    s.len  = 3'd1;
    case (ph)
      PH_L:    begin s.b[1] = "l"; s.len = 3'd2; end
      PH_LT:   begin s.b[1] = "l"; s.b[2] = "t"; s.len = 3'd3; end
      PH_G:    begin s.b[1] = "g"; s.len = 3'd2; end
      PH_GT:   begin s.b[1] = "g"; s.b[2] = "t"; s.len = 3'd3; end
      PH_A:    begin s.b[1] = "a"; s.len = 3'd2; end
      PH_AM:   begin s.b[1] = "a"; s.b[2] = "m"; s.len = 3'd3; end
      PH_AMPW: begin s.b[1] = "a"; s.b[2] = "m"; s.b[3] = "p"; s.len = 3'd4; end
      PH_AP:   begin s.b[1] = "a"; s.b[2] = "p"; s.len = 3'd3; end
      PH_APO:  begin s.b[1] = "a"; s.b[2] = "p"; s.b[3] = "o"; s.len = 3'd4; end
      PH_APOS: begin
        s.b[1] = "a"; s.b[2] = "p"; s.b[3] = "o"; s.b[4] = "s"; s.len = 3'd5;
      end
      PH_Q:    begin s.b[1] = "q"; s.len = 3'd2; end
      PH_QU:   begin s.b[1] = "q"; s.b[2] = "u"; s.len = 3'd3; end
      PH_QUO:  begin s.b[1] = "q"; s.b[2] = "u"; s.b[3] = "o"; s.len = 3'd4; end
      PH_QUOT: begin
        s.b[1] = "q"; s.b[2] = "u"; s.b[3] = "o"; s.b[4] = "t"; s.len = 3'd5;
      end
      default: s.len = 3'd1;
    endcase
    return s;
  endfunction

  function automatic seg_t utf8_seg(input logic [15:0] code);
    seg_t s;
    s = '0;
    if (code < 16'h0080) begin
      s.b[0] = code[7:0];
      s.len  = 3'd1;
    end else if (code < 16'h0800) begin
      s.b[0] = {3'b110, code[10:6]};
      s.b[1] = {2'b10, code[5:0]};
      s.len  = 3'd2;
    end else begin
      s.b[0] = {4'b1110, code[15:12]};
      s.b[1] = {2'b10, code[11:6]};
      s.b[2] = {2'b10, code[5:0]};
      s.len  = 3'd3;
    end
    return s;
  endfunction

endpackage

FILE: hdl/xed_front.sv
// Front end: entity matching on each input byte and assembly of its output byte group.
module xed_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // in_byte
  input  logic              in_tlast,
  input  logic              q_full,
  output logic              push,
  output xed_pkg::group_t   push_data
);

  xed_pkg::phase_t phase_r, phase_nxt, ph_mid, nx;
  logic [15:0]     acc_r, acc_nxt, acc_mid, acc_dec, acc_hex;
  xed_pkg::act_t   act;
  logic            plain_go, b_emit, flush;
  logic            is_dec, is_hex, is_semi;
  logic [3:0]      hex_v;
  logic [7:0]      b, done_c;
  xed_pkg::seg_t   seg_a, seg_c;
  logic [3:0]      ab_len, total;
  logic            accept;

  assign b       = in_tdata;
  assign is_dec  = b inside {[8'h30:8'h39]};
  assign is_hex  = is_dec || (b inside {[8'h41:8'h46], [8'h61:8'h66]});
  assign is_semi = (b == xed_pkg::CH_SEMI);
  assign hex_v   = is_dec ? b[3:0] : b[3:0] + 4'd9;
  assign acc_dec = 16'({acc_r, 3'b000} + {acc_r, 1'b0} + {15'b0, b[3:0]});
  assign acc_hex = {acc_r[11:0], hex_v};
  assign nx      = xed_pkg::named_next(phase_r, b);
  assign done_c  = xed_pkg::done_char(phase_r);

  always_comb begin
    ph_mid   = phase_r;
    acc_mid  = acc_r;
    act      = xed_pkg::ACT_NONE;
    plain_go = 1'b0;
    case (phase_r)
      xed_pkg::PH_IDLE: begin
        plain_go = 1'b1;
      end
      xed_pkg::PH_HASH: begin
        if (is_dec) begin
          acc_mid = {12'b0, b[3:0]};
          ph_mid  = xed_pkg::PH_DEC;
        end else if (b == "x" || b == "X") begin
          acc_mid = '0;
          ph_mid  = xed_pkg::PH_HEX;
        end else begin
          act      = xed_pkg::ACT_NUM;
          ph_mid   = xed_pkg::PH_IDLE;
          acc_mid  = '0;
          plain_go = !is_semi;
        end
      end
      xed_pkg::PH_DEC: begin
        if (is_dec) begin
          acc_mid = acc_dec;
        end else begin
          act      = xed_pkg::ACT_NUM;
          ph_mid   = xed_pkg::PH_IDLE;
          acc_mid  = '0;
          plain_go = !is_semi;
        end
      end
      xed_pkg::PH_HEX: begin
        if (is_hex) begin
          acc_mid = acc_hex;
        end else begin
          act      = xed_pkg::ACT_NUM;
          ph_mid   = xed_pkg::PH_IDLE;
          acc_mid  = '0;
          plain_go = !is_semi;
        end
      end
      default: begin
        if (is_semi && done_c != 8'h00) begin
          act    = xed_pkg::ACT_DONE;
          ph_mid = xed_pkg::PH_IDLE;
        end else if (nx != xed_pkg::PH_IDLE) begin
          ph_mid = nx;
          if (nx == xed_pkg::PH_HASH) acc_mid = '0;
        end else begin
          act      = xed_pkg::ACT_HELD;
          ph_mid   = xed_pkg::PH_IDLE;
          plain_go = 1'b1;
        end
      end
    endcase
    if (plain_go && b == xed_pkg::CH_AMP) begin
      ph_mid  = xed_pkg::PH_AMP;
      acc_mid = '0;
    end
    b_emit    = plain_go && (b != xed_pkg::CH_AMP);
    flush     = in_tlast && (ph_mid != xed_pkg::PH_IDLE);
    phase_nxt = flush ? xed_pkg::PH_IDLE : ph_mid;
    acc_nxt   = flush ? 16'h0000 : acc_mid;
  end

  always_comb begin
    logic [3:0] j;
    case (act)
      xed_pkg::ACT_NUM:  seg_a = xed_pkg::utf8_seg(acc_r);
      xed_pkg::ACT_DONE: begin
        seg_a      = '0;
        seg_a.b[0] = done_c;
        seg_a.len  = 3'd1;
      end
      xed_pkg::ACT_HELD: seg_a = xed_pkg::held_seg(phase_r);
      default:           seg_a = '0;
    endcase
    if (!flush) begin
      seg_c = '0;
    end else if (ph_mid == xed_pkg::PH_HASH || ph_mid == xed_pkg::PH_DEC ||
                 ph_mid == xed_pkg::PH_HEX) begin
      seg_c = xed_pkg::utf8_seg(acc_mid);
    end else begin
      seg_c = xed_pkg::held_seg(ph_mid);
    end
    ab_len = {1'b0, seg_a.len} + {3'b000, b_emit};
    total  = ab_len + {1'b0, seg_c.len};
    for (int k = 0; k < xed_pkg::MAX_OUT; k++) begin
      j = 4'(k) - ab_len;
      if (4'(k) < {1'b0, seg_a.len}) begin
        push_data.b[k] = seg_a.b[k];
      end else if (4'(k) < ab_len) begin
        push_data.b[k] = b;
      end else if (j < 4'(xed_pkg::SEG_MAX)) begin
        push_data.b[k] = seg_c.b[j[2:0]];
      end else begin
        push_data.b[k] = 8'h00;
      end
    end
    push_data.cnt = (total > 4'(xed_pkg::MAX_OUT)) ? 3'(xed_pkg::MAX_OUT) : total[2:0];
  end

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign push      = accept && (total != 4'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= xed_pkg::PH_IDLE;
      acc_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
    end
  end

endmodule

FILE: hdl/xed_queue.sv
// Short queue of output byte groups between the front and back ends.
module xed_queue #(
  parameter int DEPTH = xed_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  xed_pkg::group_t   push_data,
  output logic              full,
  input  logic              pop,
  output xed_pkg::q_head_t  head
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  xed_pkg::group_t mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full       = (count_r == CW'(DEPTH));
  assign head.valid = (count_r != '0);
  assign head.grp   = mem[rd_ptr_r];

  assign wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_nxt;
      if (pop) rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("Group pushed into a full queue.");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("Queue count exceeds its depth.");
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n) pop |-> head.valid)
    else $error("Group popped from an empty queue.");

endmodule

FILE: hdl/xed_back.sv
// Back end: sends the bytes of the queued groups one per request, tlast on each group's end.
module xed_back (
  input  logic              clk,
  input  logic              rst_n,
  input  xed_pkg::q_head_t  head,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,   // out_byte
  output logic              out_tlast
);

  logic [2:0] idx_r, idx_nxt;
  logic       accept;

  assign out_tvalid = head.valid;
  assign out_tdata  = head.grp.b[idx_r];
  assign out_tlast  = head.valid && (idx_r == head.grp.cnt - 3'd1);
  assign accept     = out_tvalid && out_tready;
  assign pop        = accept && out_tlast;
  assign idx_nxt    = out_tlast ? 3'd0 : idx_r + 3'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 3'd0;
    end else if (accept) begin
      idx_r <= idx_nxt;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    head.valid |-> (idx_r < head.grp.cnt))
    else $error("Byte index runs past the end of its group.");
  a_last_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (idx_r == 3'd0))
    else $error("Byte index not rewound after the end of a group.");

endmodule

FILE: hdl/xml_entity_decoder_core.sv
// Top level of the XML entity decoder: front end, group queue and back end.
// Each accepted input byte's output group is registered in the queue before it is offered.
// Throughput: one input byte per cycle while out_tready is high and each input byte yields
// at most one output byte. An input yielding n bytes holds the single output port until all
// n are out. The QUEUE_DEPTH-group queue absorbs bursts; input stalls only when it is full.
// Reset is synchronous, active low; it clears the match phase, the code and the queue.
module xml_entity_decoder_core #(
  parameter int QUEUE_DEPTH = xed_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // out_byte
  output logic       out_tlast
);

  logic              push, q_full, pop;
  xed_pkg::group_t   push_data;
  xed_pkg::q_head_t  head;

  xed_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  xed_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head      (head)
  );

  xed_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the XML entity decoder: stream stimulus with a scoreboard.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEM_TARGET = 200;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  typedef enum {RX_OPEN, RX_TOGGLE, RX_RANDOM} rx_mode_t;

  class entity_decode_scoreboard;
    xed_pkg::phase_t phase;
    logic [15:0]     code;
    string           held;
    string           names[5];
    logic [7:0]      step_bytes[$];
    byte_item_t      decoded_q[$];
    int              errors;

    function new();
      names  = '{"lt", "gt", "amp", "apos", "quot"};
      phase  = xed_pkg::PH_IDLE;
      code   = '0;
      held   = "";
      errors = 0;
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction

    function bit name_prefix(string s);
      foreach (names[i]) begin
        if (s.len() <= names[i].len() && names[i].substr(0, s.len() - 1) == s) return 1;
      end
      return 0;
    endfunction

    function logic [7:0] name_char(string s);
      case (s)
        "lt":    return "<";
        "gt":    return ">";
        "amp":   return xed_pkg::CH_AMP;
        "apos":  return "'";
        "quot":  return 8'h22;
        default: return 8'h00;
      endcase
    endfunction

    function int digit_value(logic [7:0] b, bit hex);
      if (b >= "0" && b <= "9") return b - "0";
      if (hex && b >= "a" && b <= "f") return b - "a" + 10;
      if (hex && b >= "A" && b <= "F") return b - "A" + 10;
      return 16;
    endfunction

    function void put_utf8(logic [15:0] c);
      if (c < 16'h0080) begin
        step_bytes.push_back(c[7:0]);
      end else if (c < 16'h0800) begin
        step_bytes.push_back(8'hC0 | 8'(c >> 6));
        step_bytes.push_back(8'h80 | 8'(c & 16'h003F));
      end else begin
        step_bytes.push_back(8'hE0 | 8'(c >> 12));
        step_bytes.push_back(8'h80 | 8'((c >> 6) & 16'h003F));
        step_bytes.push_back(8'h80 | 8'(c & 16'h003F));
      end
    endfunction

    function void put_held();
      step_bytes.push_back(xed_pkg::CH_AMP);
      for (int i = 0; i < held.len(); i++) step_bytes.push_back(held[i]);
    endfunction

    function void pass_byte(logic [7:0] b);
      if (b == xed_pkg::CH_AMP) begin
        phase = xed_pkg::PH_AMP;
        held  = "";
        code  = '0;
      end else begin
        step_bytes.push_back(b);
      end
    endfunction

    function void close_number(logic [7:0] b);
      put_utf8(code);
      phase = xed_pkg::PH_IDLE;
      code  = '0;
      if (b != xed_pkg::CH_SEMI) pass_byte(b);
    endfunction

    // All named entities share one phase; the letters matched so far live in held.
    function void take_byte(logic [7:0] b, logic last);
      int    d;
      string cand;
      step_bytes.delete();
      case (phase)
        xed_pkg::PH_IDLE: pass_byte(b);
        xed_pkg::PH_HASH: begin
          if (b >= "0" && b <= "9") begin
            code  = 16'(b - "0");
            phase = xed_pkg::PH_DEC;
          end else if (b == "x" || b == "X") begin
            code  = '0;
            phase = xed_pkg::PH_HEX;
          end else begin
            close_number(b);
          end
        end
        xed_pkg::PH_DEC: begin
          d = digit_value(b, 1'b0);
          if (d < 16) code = 16'(code * 10 + d);
          else close_number(b);
        end
        xed_pkg::PH_HEX: begin
          d = digit_value(b, 1'b1);
          if (d < 16) code = 16'(code * 16 + d);
          else close_number(b);
        end
        default: begin
          cand = {held, string'(b)};
          if (b == xed_pkg::CH_SEMI && name_char(held) != 8'h00) begin
            step_bytes.push_back(name_char(held));
            phase = xed_pkg::PH_IDLE;
            held  = "";
          end else if (held == "" && b == xed_pkg::CH_HASH) begin
            phase = xed_pkg::PH_HASH;
            code  = '0;
          end else if (b != 8'h00 && name_prefix(cand)) begin
            held = cand;
          end else begin
            put_held();
            phase = xed_pkg::PH_IDLE;
            held  = "";
            pass_byte(b);
          end
        end
      endcase
      if (last && phase != xed_pkg::PH_IDLE) begin
        if (phase == xed_pkg::PH_HASH || phase == xed_pkg::PH_DEC ||
            phase == xed_pkg::PH_HEX) put_utf8(code);
        else put_held();
        phase = xed_pkg::PH_IDLE;
        code  = '0;
        held  = "";
      end
      while (step_bytes.size() > xed_pkg::MAX_OUT) void'(step_bytes.pop_back());
      foreach (step_bytes[k]) begin
        decoded_q.push_back('{data: step_bytes[k], last: (k == step_bytes.size() - 1)});
      end
    endfunction

    function void check_output(logic [7:0] data, logic last);
      byte_item_t e;
      if (decoded_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected output: expected none, actual %02h last %0b",
                 $time, data, last);
        return;
      end
      e = decoded_q.pop_front();
      if (data !== e.data) begin
        errors++;
        $display("%0t: out_tdata mismatch: expected %02h, actual %02h", $time, e.data, data);
      end
      if (last !== e.last) begin
        errors++;
        $display("%0t: out_tlast mismatch: expected %0b, actual %0b", $time, e.last, last);
      end
    endfunction
  endclass

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;

  entity_decode_scoreboard decode_sb = new();
  byte_item_t text_q[$];
  string      entity_names[5] = '{"lt", "gt", "amp", "apos", "quot"};
  string      noise_chars     = "&#;xXlgaqtuop0F9";
  int         burst_left      = 0;
  int         sent_count      = 0;
  int         idle_cycles     = 0;
  int         hold_left       = 0;
  int         rx_left         = 0;
  bit         hold_req        = 1'b0;
  rx_mode_t   rx_mode         = RX_OPEN;

  xml_entity_decoder_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) decode_sb.check_output(out_tdata, out_tlast);
      if (in_tvalid && in_tready) decode_sb.take_byte(in_tdata, in_tlast);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready = 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        rx_left = $urandom_range(10, 60);
      end
      rx_left--;
      case (rx_mode)
        RX_OPEN:   out_tready = 1'b1;
        RX_TOGGLE: out_tready = ~out_tready;
        default:   out_tready = ($urandom_range(0, 9) < 6);
      endcase
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    text_q.push_back('{data: b, last: last});
  endtask

  task automatic push_text(input string s, input bit last_end);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], last_end && (i == s.len() - 1));
  endtask

  task automatic push_end();
    int pick;
    pick = $urandom_range(0, 4);
    case (pick)
      0, 1: push_byte(xed_pkg::CH_SEMI, 1'b0);
      2:    push_byte(8'($urandom_range(0, 255)), 1'b0);
      3:    push_byte(xed_pkg::CH_AMP, 1'b0);
      default: ;
    endcase
  endtask

  // Random bytes, well-formed and broken entities with random content, and noise characters.
  task automatic push_random_text();
    int         kind;
    int         n;
    int         v;
    string      nm;
    logic [7:0] c;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1: begin
        n = $urandom_range(1, 4);
        repeat (n) push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 29) == 0);
      end
      2, 3: begin
        nm = entity_names[$urandom_range(0, 4)];
        push_text({"&", nm, ";"}, 1'b0);
      end
      4: begin
        nm = entity_names[$urandom_range(0, 4)];
        push_text({"&", nm.substr(0, $urandom_range(0, nm.len()) - 1)}, 1'b0);
        v = $urandom_range(0, 3);
        if (v == 0) push_byte(8'($urandom_range(0, 255)), 1'b0);
        else if (v == 1) push_byte(noise_chars[$urandom_range(0, noise_chars.len() - 1)], 1'b0);
        else if (v == 2) push_byte(xed_pkg::CH_SEMI, 1'b0);
      end
      5, 6: begin
        push_text("&#", 1'b0);
        n = $urandom_range(0, 6);
        repeat (n) push_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
        push_end();
      end
      7, 8: begin
        push_text($urandom_range(0, 1) ? "&#x" : "&#X", 1'b0);
        n = $urandom_range(0, 5);
        repeat (n) begin
          v = $urandom_range(0, 15);
          if (v < 10) c = 8'("0" + v);
          else c = 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
          push_byte(c, 1'b0);
        end
        push_end();
      end
      default: begin
        n = $urandom_range(1, 6);
        repeat (n) push_byte(noise_chars[$urandom_range(0, noise_chars.len() - 1)], 1'b0);
      end
    endcase
    if (text_q.size() != 0 && $urandom_range(0, 5) == 0) text_q[$].last = 1'b1;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_text();
    byte_item_t it;
    while (text_q.size() != 0) begin
      it = text_q.pop_front();
      send_byte(it.data, it.last);
      sent_count++;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (decode_sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    bit held_off;
    bit paused;
    held_off = 1'b0;
    paused   = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_text("&lt;", 1'b0);
    push_text("&am", 1'b0);
    push_text("&#X1g", 1'b0);
    push_text("&#;", 1'b0);
    push_text("&qu", 1'b1);
    push_text("&#x", 1'b1);
    send_text();
    wait_drained();

    while (sent_count < ITEM_TARGET) begin
      push_random_text();
      send_text();
      if (!held_off && sent_count >= 100) begin
        held_off = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && sent_count >= 160) begin
        paused = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    if (decode_sb.errors == 0 && decode_sb.pending() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
